// ===== src/tsf_pkg.sv =====
// Package for the triangle scanline filler: shared types and state encoding.
// No dependencies.
`timescale 1ns / 1ps
package tsf_pkg;
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT,
		ST_X4,
		ST_BS1,
		ST_BS2,
		ST_BOT,
		ST_TS1,
		ST_TS2,
		ST_TOP,
		ST_FLAT
	} tsf_state_t;

	typedef enum logic [2:0] {
		DSEL_X4,
		DSEL_BS1,
		DSEL_BS2,
		DSEL_TS1,
		DSEL_TS2
	} tsf_dsel_t;

	typedef struct packed {
		logic      load;
		logic      sort;
		logic      div_start;
		tsf_dsel_t dsel;
		logic      latch_x4;
		logic      latch_s1;
		logic      latch_s2;
		logic      bot_init;
		logic      top_init;
		logic      bot_step;
		logic      top_step;
		logic      flat;
		logic      emit;
	} tsf_cmd_t;

	typedef struct packed {
		logic all_flat;
		logic bottom_only;
		logic top_only;
		logic div_busy;
		logic bot_done;
		logic top_done;
		logic out_busy;
	} tsf_status_t;
endpackage

// ===== src/tsf_if.sv =====
// Valid/ready stream interface carrying one payload word.
// No dependencies.
`timescale 1ns / 1ps
interface tsf_if #(parameter int W = 18);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/triangle_scanline_filler.sv =====
// Top level: triangle in, spans out.
// Depends on tsf_pkg, tsf_if, tsf_ctrl, tsf_datapath.
//  channel | dir | payload
//  tri_in  | in  | first_x..third_y (6 bits each)
//  span_out| out | span_row, span_left, span_right, last_span
// Each division runs in steps: start, one quotient bit a cycle, latch. A split
// triangle needs five divisions, a flat-bottom or flat-top one two, a one-row
// triangle none. Accept and sort come first; the spans are emitted in the walks.
// Reset clears the controller and the output valid. A stalled output holds the
// span walk; the input is taken only when the block is idle.
`timescale 1ns / 1ps
module triangle_scanline_filler import tsf_pkg::*; #(
	parameter int GRID_SIZE = 64,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	tsf_if.sink   tri_in,
	tsf_if.source span_out
);
	localparam int CW = 6;
	tsf_cmd_t cmd;
	tsf_status_t sts;
	logic [CW-1:0] c [6];
	logic [CW-1:0] lim;
	logic [CW-1:0] row, l, r;
	logic lst;
	assign lim = CW'(GRID_SIZE - 1);
	always_comb
		for (int i = 0; i < 6; i++) begin
			c[i] = tri_in.data[i*CW +: CW];
			if (c[i] > lim) c[i] = lim;
		end
	tsf_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(tri_in.valid),
		.in_ready(tri_in.ready), .sts(sts), .cmd(cmd));
	tsf_datapath #(.CW(CW), .FB(FRAC_BITS)) u_dp (.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .sts(sts), .in_c(c), .out_valid(span_out.valid),
		.out_ready(span_out.ready), .o_row(row), .o_left(l), .o_right(r), .o_last(lst));
	assign span_out.data = {lst, r, l, row};
endmodule

// ===== src/tsf_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on nothing.
`timescale 1ns / 1ps
module tsf_div #(
	parameter int NW = 30,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          busy,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   sh;
	always_comb sh = {r_q[DW-1:0], q_q[NW-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (cnt_q != '0) begin
			if (sh >= {1'b0, d_q}) begin
				r_q <= sh - {1'b0, d_q};
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
	assign busy = (cnt_q != '0);
	assign quo = q_q;
	assign rem = r_q[DW-1:0];
endmodule

// ===== src/tsf_datapath.sv =====
// Datapath: vertex sort, split point, slopes, edge accumulators, output register.
// Depends on tsf_pkg and tsf_div.
`timescale 1ns / 1ps
module tsf_datapath import tsf_pkg::*; #(
	parameter int CW = 6,
	parameter int FB = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tsf_cmd_t        cmd,
	output tsf_status_t     sts,
	input  logic [CW-1:0]   in_c [6],
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CW-1:0]   o_row,
	output logic [CW-1:0]   o_left,
	output logic [CW-1:0]   o_right,
	output logic            o_last
);
	localparam int SW = CW + FB + 2;
	localparam int NW = CW + FB;
	localparam int PW = 2 * CW;
	logic [CW-1:0] x_q [3];
	logic [CW-1:0] y_q [3];
	logic [CW-1:0] x4_q;
	logic signed [SW-1:0] s1_q, s2_q, c1_q, c2_q;
	logic [CW-1:0] row_q, stop_q;
	logic neg_q;
	logic div_busy;
	logic [NW-1:0] div_num, div_quo;
	logic [CW-1:0] div_den, div_rem;
	logic [CW-1:0] sx [3];
	logic [CW-1:0] sy [3];
	logic [CW-1:0] pa, pb, ya, yb, dyl;
	logic neg;
	logic [CW-1:0] mag;
	logic [PW-1:0] pmag;
	logic split;
	logic signed [SW-1:0] quo_s, slope;
	logic signed [SW-1:0] start0, start2;
	logic [CW-1:0] cl [2];
	logic ov_q, last_q;
	logic [CW-1:0] orow_q, ol_q, or_q;
	logic last_row;
	logic all_flat, bot_only, top_only, bot_done, top_done;

	function automatic logic bef(input logic [CW-1:0] px, py, qx, qy);
		return (py == qy) ? (px < qx) : (py < qy);
	endfunction

	function automatic logic [CW-1:0] col_of(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] m;
		m = (v < 0) ? -v : v;
		m = m >>> FB;
		return (v < 0) ? CW'(-m) : CW'(m);
	endfunction

	always_comb begin
		logic [CW-1:0] tx, ty;
		tx = '0; ty = '0;
		sx = x_q; sy = y_q;
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2 - i; j++)
				if (bef(sx[j+1], sy[j+1], sx[j], sy[j])) begin
					tx = sx[j]; ty = sy[j];
					sx[j] = sx[j+1]; sy[j] = sy[j+1];
					sx[j+1] = tx; sy[j+1] = ty;
				end
	end

	assign split = (y_q[0] != y_q[1]) && (y_q[1] != y_q[2]);

	always_comb begin
		unique case (cmd.dsel)
			DSEL_BS1: begin pa = x_q[0]; pb = x_q[1]; ya = y_q[0]; yb = y_q[1]; end
			DSEL_BS2: begin
				pa = x_q[0]; pb = split ? x4_q : x_q[2]; ya = y_q[0]; yb = y_q[1];
			end
			DSEL_TS1: begin
				pa = split ? x_q[1] : x_q[0]; pb = x_q[2]; ya = y_q[1]; yb = y_q[2];
			end
			DSEL_TS2: begin
				pa = split ? x4_q : x_q[1]; pb = x_q[2]; ya = y_q[1]; yb = y_q[2];
			end
			default: begin pa = x_q[0]; pb = x_q[2]; ya = y_q[0]; yb = y_q[2]; end
		endcase
		neg = pb < pa;
		mag = neg ? pa - pb : pb - pa;
		dyl = y_q[1] - y_q[0];
		pmag = PW'(mag) * PW'(dyl);
		if (cmd.dsel == DSEL_X4)
			div_num = NW'(pmag);
		else
			div_num = {mag, {FB{1'b0}}};
		div_den = yb - ya;
	end

	tsf_div #(.NW(NW), .DW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo), .rem(div_rem)
	);

	assign quo_s = $signed(SW'(div_quo));
	assign slope = neg_q ? -quo_s : quo_s;
	assign start0 = $signed(SW'({x_q[0], {FB{1'b0}}}));
	assign start2 = $signed(SW'({x_q[2], {FB{1'b0}}}));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				x_q[i] <= in_c[2*i];
				y_q[i] <= in_c[2*i+1];
			end
		end
		if (cmd.sort) begin
			x_q <= sx; y_q <= sy;
		end
		if (cmd.div_start) neg_q <= neg;
		if (cmd.latch_x4) begin
			// floor for a negative split quotient
			if (neg_q) x4_q <= x_q[0] - CW'(div_quo) - CW'(div_rem != '0);
			else       x4_q <= x_q[0] + CW'(div_quo);
		end
		if (cmd.latch_s1) s1_q <= slope;
		if (cmd.latch_s2) s2_q <= slope;
		if (cmd.bot_init) begin
			c1_q <= start0; c2_q <= start0;
			row_q <= y_q[0]; stop_q <= y_q[1];
		end
		if (cmd.top_init) begin
			c1_q <= start2; c2_q <= start2;
			row_q <= y_q[2]; stop_q <= y_q[1];
		end
		if (cmd.bot_step) begin
			c1_q <= c1_q + s1_q;
			c2_q <= c2_q + s2_q;
			row_q <= row_q + 1'b1;
		end
		if (cmd.top_step) begin
			c1_q <= c1_q - s1_q;
			c2_q <= c2_q - s2_q;
			row_q <= row_q - 1'b1;
		end
		if (cmd.emit) begin
			orow_q <= cmd.flat ? y_q[0] : row_q;
			ol_q <= (cl[0] < cl[1]) ? cl[0] : cl[1];
			or_q <= (cl[0] < cl[1]) ? cl[1] : cl[0];
			last_q <= last_row;
		end
	end

	always_comb begin
		if (cmd.flat) begin
			cl[0] = x_q[0]; cl[1] = x_q[2];
		end else begin
			cl[0] = col_of(c1_q); cl[1] = col_of(c2_q);
		end
		last_row = cmd.flat || (cmd.top_step && top_done) ||
			(cmd.bot_step && bot_done && bot_only);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.emit) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	assign all_flat = (sy[0] == sy[2]);
	assign bot_only = (sy[1] == sy[2]) && !all_flat;
	assign top_only = (sy[0] == sy[1]) && !all_flat;
	assign bot_done = (row_q == stop_q);
	assign top_done = (row_q == stop_q + 1'b1);

	assign out_valid = ov_q;
	assign o_row = orow_q;
	assign o_left = ol_q;
	assign o_right = or_q;
	assign o_last = last_q;

	assign sts.all_flat = all_flat;
	assign sts.bottom_only = bot_only;
	assign sts.top_only = top_only;
	assign sts.div_busy = div_busy;
	assign sts.bot_done = bot_done;
	assign sts.top_done = top_done;
	assign sts.out_busy = ov_q && !out_ready;
endmodule

// ===== src/tsf_ctrl.sv =====
// Controller: sequences sort, divisions and span walks.
// Depends on tsf_pkg.
`timescale 1ns / 1ps
module tsf_ctrl import tsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  tsf_status_t sts,
	output tsf_cmd_t    cmd
);
	tsf_state_t st_q, st_d;
	logic go_q, go_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			go_q <= 1'b0;
		end else begin
			st_q <= st_d;
			go_q <= go_d;
		end
	end
	always_comb begin
		st_d = st_q; go_d = go_q; cmd = '0;
		in_ready = (st_q == ST_IDLE);
		unique case (st_q)
			ST_IDLE: if (in_valid) begin cmd.load = 1'b1; st_d = ST_SORT; end
			ST_SORT: begin
				cmd.sort = 1'b1;
				go_d = 1'b0;
				priority if (sts.all_flat) st_d = ST_FLAT;
				else if (sts.bottom_only) st_d = ST_BS1;
				else if (sts.top_only) st_d = ST_TS1;
				else st_d = ST_X4;
			end
			ST_X4, ST_BS1, ST_BS2, ST_TS1, ST_TS2: begin
				unique case (st_q)
					ST_X4:   cmd.dsel = DSEL_X4;
					ST_BS1:  cmd.dsel = DSEL_BS1;
					ST_BS2:  cmd.dsel = DSEL_BS2;
					ST_TS1:  cmd.dsel = DSEL_TS1;
					default: cmd.dsel = DSEL_TS2;
				endcase
				if (!go_q) begin
					cmd.div_start = 1'b1;
					go_d = 1'b1;
				end else if (!sts.div_busy) begin
					go_d = 1'b0;
					unique case (st_q)
						ST_X4:  begin cmd.latch_x4 = 1'b1; st_d = ST_BS1; end
						ST_BS1: begin cmd.latch_s1 = 1'b1; st_d = ST_BS2; end
						ST_BS2: begin
							cmd.latch_s2 = 1'b1; cmd.bot_init = 1'b1; st_d = ST_BOT;
						end
						ST_TS1: begin cmd.latch_s1 = 1'b1; st_d = ST_TS2; end
						default: begin
							cmd.latch_s2 = 1'b1; cmd.top_init = 1'b1; st_d = ST_TOP;
						end
					endcase
				end
			end
			ST_BOT: if (!sts.out_busy) begin
				cmd.emit = 1'b1; cmd.bot_step = 1'b1;
				if (sts.bot_done) st_d = sts.bottom_only ? ST_IDLE : ST_TS1;
			end
			ST_TOP: if (!sts.out_busy) begin
				cmd.emit = 1'b1; cmd.top_step = 1'b1;
				if (sts.top_done) st_d = ST_IDLE;
			end
			ST_FLAT: if (!sts.out_busy) begin
				cmd.emit = 1'b1; cmd.flat = 1'b1; st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end
endmodule

// ===== src/tsf_checker.sv =====
// Port checker for the triangle scanline filler, with bind.
// Depends on nothing.
`timescale 1ns / 1ps
module tsf_checker (
	input logic clk,
	input logic arst_n,
	input logic iv, ir, ov, orr,
	input logic [18:0] od
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !orr |=> ov && $stable(od)) else $error("span dropped");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		iv && ir |=> !ir) else $error("second request taken");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		ov && !od[18] |-> !ir) else $error("taken mid triangle");
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		ov |-> od[17:12] >= od[11:6]) else $error("span reversed");
endmodule
bind triangle_scanline_filler tsf_checker u_chk (.clk(clk), .arst_n(arst_n),
	.iv(tri_in.valid), .ir(tri_in.ready), .ov(span_out.valid),
	.orr(span_out.ready), .od(span_out.data[18:0]));
